// ----- rtl/ordered_set_store_unit_macros.svh -----
// Assertion macros used by the ordered set store checker.
`ifndef ORDERED_SET_STORE_UNIT_MACROS_SVH
`define ORDERED_SET_STORE_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define OSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define OSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/oss_pkg.sv -----
// Shared types and constants of the ordered set store.
package oss_pkg;

  localparam int KIND_W      = 2;
  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 5;

  // Request opcodes
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_CMP,
    ST_HIT,
    ST_MISS,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RESP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture request, rewind scan index
    logic rd_en;     // read entry at scan index
    logic idx_inc;   // advance scan index
    logic append;    // write request value at slot count, count up
    logic shift_wr;  // write read data one slot below scan index
    logic cnt_dec;   // count down after a removal
    logic cnt_clr;   // empty the set
    logic set_hit;
    logic set_rej;
    logic respond;   // register and strobe the result
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  match;     // read data equals request value
    logic  idx_last;  // scan index is at the last member
    logic  cnt_zero;
    logic  cnt_full;
  } dp_stat_t;

endpackage

// ----- rtl/oss_ctrl.sv -----
// Sequencer of the ordered set store: scan, append, shift-down and response steps.
module oss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  oss_pkg::dp_stat_t stat,
  output oss_pkg::dp_cmd_t  cmd
);

  oss_pkg::state_t state_r;
  oss_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      oss_pkg::ST_IDLE: begin
        if (start) state_nxt = oss_pkg::ST_DISPATCH;
      end
      oss_pkg::ST_DISPATCH: begin
        if (stat.kind == oss_pkg::KIND_CLEAR) state_nxt = oss_pkg::ST_RESP;
        else if (stat.cnt_zero)               state_nxt = oss_pkg::ST_MISS;
        else                                  state_nxt = oss_pkg::ST_READ;
      end
      oss_pkg::ST_READ: begin
        state_nxt = oss_pkg::ST_CMP;
      end
      oss_pkg::ST_CMP: begin
        if (stat.match)         state_nxt = oss_pkg::ST_HIT;
        else if (stat.idx_last) state_nxt = oss_pkg::ST_MISS;
        else                    state_nxt = oss_pkg::ST_READ;
      end
      oss_pkg::ST_HIT: begin
        if (stat.kind == oss_pkg::KIND_REMOVE && !stat.idx_last) begin
          state_nxt = oss_pkg::ST_SHIFT_RD;
        end else begin
          state_nxt = oss_pkg::ST_RESP;
        end
      end
      oss_pkg::ST_MISS: begin
        state_nxt = oss_pkg::ST_RESP;
      end
      oss_pkg::ST_SHIFT_RD: begin
        state_nxt = oss_pkg::ST_SHIFT_WR;
      end
      oss_pkg::ST_SHIFT_WR: begin
        if (stat.idx_last) state_nxt = oss_pkg::ST_RESP;
        else               state_nxt = oss_pkg::ST_SHIFT_RD;
      end
      oss_pkg::ST_RESP: begin
        state_nxt = oss_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = oss_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      oss_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      oss_pkg::ST_DISPATCH: begin
        cmd.cnt_clr = (stat.kind == oss_pkg::KIND_CLEAR);
      end
      oss_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      oss_pkg::ST_CMP: begin
        cmd.idx_inc = !stat.match && !stat.idx_last;
      end
      oss_pkg::ST_HIT: begin
        unique case (stat.kind) inside
          oss_pkg::KIND_QUERY: begin
            cmd.set_hit = 1'b1;
          end
          oss_pkg::KIND_REMOVE: begin
            // last member goes by dropping the count, others need a shift-down
            if (stat.idx_last) begin
              cmd.cnt_dec = 1'b1;
              cmd.set_hit = 1'b1;
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
          oss_pkg::KIND_ADD, oss_pkg::KIND_CLEAR: begin
          end
        endcase
      end
      oss_pkg::ST_MISS: begin
        if (stat.kind == oss_pkg::KIND_ADD) begin
          if (stat.cnt_full) begin
            cmd.set_rej = 1'b1;
          end else begin
            cmd.append  = 1'b1;
            cmd.set_hit = 1'b1;
          end
        end
      end
      oss_pkg::ST_SHIFT_RD: begin
        cmd.rd_en = 1'b1;
      end
      oss_pkg::ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        if (stat.idx_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.set_hit = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      oss_pkg::ST_RESP: begin
        cmd.respond = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state_r != oss_pkg::ST_IDLE);

endmodule

// ----- rtl/oss_dp.sv -----
// Datapath of the ordered set store: member memory, count, scan index and result registers.
module oss_dp #(
  parameter int SLOTS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [oss_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [oss_pkg::VALUE_W-1:0]  in_value,
  input  oss_pkg::dp_cmd_t                    cmd,
  output oss_pkg::dp_stat_t                   stat,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic                                out_full_reject,
  output logic [oss_pkg::COUNT_OUT_W-1:0]     out_member_count,
  output logic                                out_is_empty
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic signed [oss_pkg::VALUE_W-1:0] mem_r [SLOTS];
  logic signed [oss_pkg::VALUE_W-1:0] rdata_r;

  oss_pkg::kind_t                     kind_r;
  logic signed [oss_pkg::VALUE_W-1:0] value_r;
  logic [CNT_W-1:0]                   cnt_r;
  logic [CNT_W-1:0]                   cnt_nxt;
  logic [CNT_W-1:0]                   idx_r;
  logic [CNT_W-1:0]                   idx_nxt;
  logic [CNT_W-1:0]                   idx_m1;
  logic                               hit_r;
  logic                               rej_r;

  logic                               wr_en;
  logic [IDX_W-1:0]                   wr_addr;
  logic signed [oss_pkg::VALUE_W-1:0] wr_data;

  logic                               out_valid_r;
  logic                               out_hit_r;
  logic                               out_rej_r;
  logic [oss_pkg::COUNT_OUT_W-1:0]    out_cnt_r;
  logic                               out_empty_r;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= oss_pkg::kind_t'(in_kind);
      value_r <= in_value;
    end
  end

  // Member memory: one write port, one registered read port
  assign idx_m1  = idx_r - 1'b1;
  assign wr_en   = cmd.append | cmd.shift_wr;
  assign wr_addr = cmd.append ? cnt_r[IDX_W-1:0] : idx_m1[IDX_W-1:0];
  assign wr_data = cmd.append ? value_r : rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem_r[idx_r[IDX_W-1:0]];
    end
  end

  // Count and scan index
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr)     cnt_nxt = '0;
    else if (cmd.append) cnt_nxt = cnt_r + 1'b1;
    else if (cmd.cnt_dec) cnt_nxt = cnt_r - 1'b1;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load)         idx_nxt = '0;
    else if (cmd.idx_inc) idx_nxt = idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
      hit_r <= 1'b0;
      rej_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      if (cmd.load) begin
        hit_r <= 1'b0;
        rej_r <= 1'b0;
      end else begin
        if (cmd.set_hit) hit_r <= 1'b1;
        if (cmd.set_rej) rej_r <= 1'b1;
      end
    end
  end

  // Status to the sequencer
  assign stat.kind     = kind_r;
  assign stat.match    = (rdata_r == value_r);
  assign stat.idx_last = (({1'b0, idx_r} + 1'b1) >= {1'b0, cnt_r});
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.cnt_full = (cnt_r == CNT_W'(SLOTS));

  // Result registers, strobed for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_hit_r   <= hit_r;
      out_rej_r   <= rej_r;
      out_cnt_r   <= oss_pkg::COUNT_OUT_W'(cnt_r);
      out_empty_r <= (cnt_r == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_full_reject  = out_rej_r;
  assign out_member_count = out_cnt_r;
  assign out_is_empty     = out_empty_r;

endmodule

// ----- rtl/ordered_set_store_unit.sv -----
// Top level of the ordered set store: sequencer plus datapath.
//
// Keeps up to SLOTS distinct 32-bit signed values in joining order, packed from slot 0.
// Request channel: in_kind (add, remove, query, clear) and in_value are taken at a rising
// edge where start is high and busy is low. busy stays high until the request is answered.
// Result channel: out_valid is high for exactly one cycle with out_hit, out_full_reject,
// out_member_count and out_is_empty. The receiver cannot stall; every result is taken.
// One result per request, in request order; a new request may be issued in the cycle
// the previous result is shown.
// Members sit in a memory with one write port and one registered read port, scanned one
// entry at a time from slot 0 (read, then compare registered data) until a match or the
// last member; a remove with a match then shifts each later member down one slot, and a
// clear skips the scan.
// Reset (synchronous, rst_n low) empties the set and idles the sequencer; memory
// contents are not cleared, only slots below the count are ever read.
module ordered_set_store_unit #(
  parameter int SLOTS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [oss_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [oss_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic                                out_full_reject,
  output logic [oss_pkg::COUNT_OUT_W-1:0]     out_member_count,
  output logic                                out_is_empty
);

  oss_pkg::dp_cmd_t  cmd;
  oss_pkg::dp_stat_t stat;

  // Sequencer
  oss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Storage and result registers
  oss_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_full_reject  (out_full_reject),
    .out_member_count (out_member_count),
    .out_is_empty     (out_is_empty)
  );

endmodule

// ----- rtl/oss_checker.sv -----
// Port-level checker of the ordered set store and its bind to the top level.
`include "ordered_set_store_unit_macros.svh"

module oss_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic                            out_hit,
  input logic                            out_full_reject,
  input logic [oss_pkg::COUNT_OUT_W-1:0] out_member_count,
  input logic                            out_is_empty
);

  // an accepted request holds the block busy in the next cycle
  `OSS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

  // the result strobe lasts one cycle and lands once the block is free
  `OSS_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe held two cycles")
  `OSS_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result shown while still busy")

  // a rejected add never counts as inserted, and needs a full, non-empty set
  `OSS_ASSERT_IMP(a_reject, out_valid && out_full_reject, !out_hit && !out_is_empty, "bad reject")

  // an empty set reports a zero count
  `OSS_ASSERT_IMP(a_empty_count, out_valid && out_is_empty, out_member_count == '0, "bad empty")

endmodule

bind ordered_set_store_unit oss_checker u_oss_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the ordered set store: command driver, result monitor, set predictor.
module testbench;
  import oss_pkg::*;

  localparam int SLOTS      = 16;
  localparam int ITEMS      = 2000;
  localparam int CALM_ITEMS = 200;
  localparam int SETTLE     = 4 * SLOTS + 8;
  localparam int STALL_MAX  = 2000;

  typedef struct {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    bit                 drain;   // hold off until every answer is back
    bit                 calm;    // no idle burst after this request
  } set_req_t;

  typedef struct packed {
    logic                   hit;
    logic                   rej;
    logic [COUNT_OUT_W-1:0] count;
    logic                   empty;
  } set_answer_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [KIND_W-1:0]           in_kind = KIND_ADD;
  logic signed [VALUE_W-1:0]   in_value = '0;
  logic                        out_valid;
  logic                        out_hit;
  logic                        out_full_reject;
  logic [COUNT_OUT_W-1:0]      out_member_count;
  logic                        out_is_empty;

  ordered_set_store_unit #(.SLOTS(SLOTS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_full_reject  (out_full_reject),
    .out_member_count (out_member_count),
    .out_is_empty     (out_is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Request stream and answers still owed by the block
  set_req_t    pending_reqs[$];
  set_answer_t owed_answers[$];

  // Predictor state: members in joining order plus the count
  logic [VALUE_W-1:0] set_slots [SLOTS];
  int                 set_count = 0;

  int errors = 0;
  int n_reqs = 0;
  int n_hits = 0;
  int n_rejects = 0;
  int n_clears = 0;
  int n_full_seen = 0;
  int n_answers = 0;
  int made = 0;

  // Next state and answer of the set for one request
  function automatic set_answer_t predict_answer(kind_t k, logic [VALUE_W-1:0] v);
    set_answer_t r;
    int pos;
    r = '0;
    pos = -1;
    for (int i = 0; i < set_count; i++)
      if (pos < 0 && set_slots[i] == v) pos = i;
    case (k)
      KIND_ADD: begin
        if (pos < 0) begin
          if (set_count < SLOTS) begin
            set_slots[set_count] = v;
            set_count++;
            r.hit = 1'b1;
          end else begin
            r.rej = 1'b1;
          end
        end
      end
      KIND_REMOVE: begin
        if (pos >= 0) begin
          for (int j = pos + 1; j < set_count; j++) set_slots[j-1] = set_slots[j];
          set_count--;
          r.hit = 1'b1;
        end
      end
      KIND_QUERY: r.hit = (pos >= 0);
      default: set_count = 0;
    endcase
    r.count = COUNT_OUT_W'(set_count);
    r.empty = (set_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on answer %0d: %s got %0d, expected %0d", n_answers, field, got, want);
    errors++;
  endtask

  task automatic push_req(kind_t k, logic [VALUE_W-1:0] v);
    set_req_t q;
    q.kind = k;
    q.value = v;
    q.drain = 1'b0;
    q.calm = (made >= ITEMS - CALM_ITEMS);
    pending_reqs.push_back(q);
    made++;
  endtask

  task automatic push_drain();
    set_req_t q;
    q.kind = KIND_QUERY;
    q.value = '0;
    q.drain = 1'b1;
    q.calm = 1'b0;
    pending_reqs.push_back(q);
  endtask

  // Driver: request accepted when start is high and busy is low
  int idle_left = 0;
  bit cur_calm = 1'b0;
  bit accepted;
  set_req_t nxt;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        owed_answers.push_back(predict_answer(kind_t'(in_kind), in_value));
        n_reqs++;
        if (kind_t'(in_kind) == KIND_CLEAR) n_clears++;
        if (!cur_calm && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 18);
      end
      if (accepted || !start) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          start <= 1'b0;
        end else if (pending_reqs[0].drain) begin
          if (!accepted && owed_answers.size() == 0) void'(pending_reqs.pop_front());
          start <= 1'b0;
        end else begin
          nxt = pending_reqs.pop_front();
          in_kind  <= nxt.kind;
          in_value <= nxt.value;
          cur_calm = nxt.calm;
          start    <= 1'b1;
        end
      end
    end
  end

  // Monitor: answers sampled mid-cycle, checked against the oldest prediction
  set_answer_t want;

  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (owed_answers.size() == 0) begin
        $display("answer with no request outstanding");
        errors++;
      end else begin
        want = owed_answers.pop_front();
        if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
        if (out_full_reject !== want.rej)
          report_mismatch("full_reject", out_full_reject, want.rej);
        if (out_member_count !== want.count)
          report_mismatch("member_count", out_member_count, want.count);
        if (out_is_empty !== want.empty) report_mismatch("is_empty", out_is_empty, want.empty);
        if (want.hit) n_hits++;
        if (want.rej) n_rejects++;
        if (want.count == SLOTS) n_full_seen++;
      end
      n_answers++;
    end
  end

  // Watchdog on cycles with no handshake at all
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("watchdog: no activity for %0d cycles, %0d answers owed",
                 stall_cycles, owed_answers.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  logic [VALUE_W-1:0] pool[$];
  int pool_size;
  int phase_len;
  int clear_pct;
  int r;
  logic [VALUE_W-1:0] v;

  initial begin
    // Directed: empty set, extremes, duplicates, mid removal, full store
    push_req(KIND_QUERY,  32'h0000_0000);
    push_req(KIND_REMOVE, 32'h8000_0000);
    push_req(KIND_ADD,    32'h8000_0000);
    push_req(KIND_ADD,    32'h7FFF_FFFF);
    push_req(KIND_ADD,    32'h0000_0000);
    push_req(KIND_ADD,    32'hFFFF_FFFF);
    push_req(KIND_ADD,    32'h7FFF_FFFF);
    push_req(KIND_QUERY,  32'hFFFF_FFFF);
    push_req(KIND_REMOVE, 32'h7FFF_FFFF);
    push_req(KIND_REMOVE, 32'h7FFF_FFFF);
    for (int i = 0; i < SLOTS - 3; i++) push_req(KIND_ADD, 32'h0000_1000 + i);
    push_req(KIND_ADD,    32'h5555_AAAA);
    push_req(KIND_ADD,    32'h8000_0000);
    push_req(KIND_REMOVE, 32'hFFFF_FFFF);
    push_req(KIND_CLEAR,  32'hFFFF_FFFF);
    push_drain();

    // Random phases over a small pool so members are hit, removed and filled
    while (made < ITEMS) begin
      pool.delete();
      pool_size = $urandom_range(2, 24);
      for (int i = 0; i < pool_size; i++) begin
        case ($urandom_range(0, 11))
          0:       pool.push_back(32'h8000_0000);
          1:       pool.push_back(32'h7FFF_FFFF);
          2:       pool.push_back(32'hFFFF_FFFF);
          3:       pool.push_back(32'h0000_0000);
          default: pool.push_back($urandom);
        endcase
      end
      phase_len = $urandom_range(50, 150);
      clear_pct = $urandom_range(0, 4);
      for (int n = 0; n < phase_len && made < ITEMS; n++) begin
        v = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
        r = $urandom_range(0, 99);
        if (r < clear_pct) push_req(KIND_CLEAR, $urandom);
        else if (r < 45) push_req(KIND_ADD, v);
        else if (r < 70) push_req(KIND_REMOVE, v);
        else push_req(KIND_QUERY, v);
      end
      if ($urandom_range(0, 3) == 0) push_drain();
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || start || owed_answers.size() != 0);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d requests: %0d hits, %0d full rejects, %0d clears, %0d full-set answers",
             n_reqs, n_hits, n_rejects, n_clears, n_full_seen);
    $display("%0d answers checked, %0d mismatches", n_answers, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/oss_pkg.sv
rtl/oss_ctrl.sv
rtl/oss_dp.sv
rtl/ordered_set_store_unit.sv
rtl/oss_checker.sv
tb/testbench.sv
